>>> rtl/sds_pkg.sv
`timescale 1ns / 1ps
// shared field widths, constants and item types of the spark delay scheduler
package sds_pkg;

    localparam int ADV_W   = 10;
    localparam int RPM_W   = 14;
    localparam int TOOTH_W = 8;
    localparam int TPD_W   = 24;
    localparam int TEETH_W = 8;
    localparam int CYL_W   = 3;
    localparam int DELAY_W = 24;

    localparam int DEF_CYLINDERS       = 4;
    localparam int DEF_ANGLE_FRAC_BITS = 6;

    localparam int MISSING_TEETH = 2;
    localparam int CYCLE_DEG     = 720;
    localparam int HALF_DEG      = 360;
    localparam int TPD_FRAC_BITS = 8;
    localparam int ADV_ROUND     = 5;
    localparam int ADV_SCALE     = 10;

    localparam int DIV_STEPS = 4;

    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    typedef enum logic {
        KIND_SCHEDULED = 1'b0,
        KIND_FALLBACK  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [ADV_W-1:0]   advance_tenths;
        logic [RPM_W-1:0]   engine_rpm;
        logic               crank_pos_ok;
        logic               pattern_locked;
        logic               crank_rev;
        logic [TOOTH_W-1:0] tooth_num;
        logic [TPD_W-1:0]   us_per_deg;
    } t_item;

    typedef struct packed {
        logic [CYL_W-1:0]   cylinder;
        t_kind              command_kind;
        logic [DELAY_W-1:0] countdown_us;
        logic [ADV_W-1:0]   advance_out;
        logic [RPM_W-1:0]   rpm_out;
        logic               last;
    } t_result;

endpackage

>>> rtl/sds_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider for the tooth angle, STEPS quotient bits per stage
module sds_div #(
    parameter int DW    = 23,
    parameter int TW    = 1,
    parameter int STEPS = sds_pkg::DIV_STEPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [DW-1:0]           i_dividend,
    input  logic [sds_pkg::TEETH_W:0] i_divisor,
    input  logic [TW-1:0]           i_tag,
    output logic                    o_valid,
    output logic [DW-1:0]           o_quotient,
    output logic [TW-1:0]           o_tag
);
    import sds_pkg::*;

    localparam int VW = TEETH_W + 1;
    localparam int NS = (DW + STEPS - 1) / STEPS;
    localparam int PW = NS * STEPS;

    logic          r_vld [NS];
    logic [VW-1:0] r_rem [NS];
    logic [PW-1:0] r_wrk [NS];
    logic [TW-1:0] r_tag [NS];

    logic          w_src_vld [NS];
    logic [VW-1:0] w_src_rem [NS];
    logic [PW-1:0] w_src_wrk [NS];
    logic [TW-1:0] w_src_tag [NS];

    logic [VW-1:0] n_rem [NS];
    logic [PW-1:0] n_wrk [NS];

    for (genvar s = 0; s < NS; s++) begin : g_src
        if (s == 0) begin : g_first
            assign w_src_vld[s] = i_valid;
            assign w_src_rem[s] = '0;
            assign w_src_wrk[s] = PW'(i_dividend);
            assign w_src_tag[s] = i_tag;
        end else begin : g_next
            assign w_src_vld[s] = r_vld[s-1];
            assign w_src_rem[s] = r_rem[s-1];
            assign w_src_wrk[s] = r_wrk[s-1];
            assign w_src_tag[s] = r_tag[s-1];
        end
    end

    always_comb begin
        logic [VW-1:0] rem_v;
        logic [PW-1:0] wrk_v;
        logic [VW:0]   trial;
        for (int s = 0; s < NS; s++) begin
            rem_v = w_src_rem[s];
            wrk_v = w_src_wrk[s];
            for (int b = 0; b < STEPS; b++) begin
                trial = {rem_v, wrk_v[PW-1]};
                wrk_v = {wrk_v[PW-2:0], 1'b0};
                if (trial >= {1'b0, i_divisor}) begin
                    trial    = trial - {1'b0, i_divisor};
                    wrk_v[0] = 1'b1;
                end
                rem_v = trial[VW-1:0];
            end
            n_rem[s] = rem_v;
            n_wrk[s] = wrk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= w_src_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            r_rem[s] <= n_rem[s];
            r_wrk[s] <= n_wrk[s];
            r_tag[s] <= w_src_tag[s];
        end
    end

    assign o_valid    = r_vld[NS-1];
    assign o_quotient = r_wrk[NS-1][DW-1:0];
    assign o_tag      = r_tag[NS-1];

endmodule

>>> rtl/spark_delay_scheduler_unit.sv
`timescale 1ns / 1ps
// spark delay scheduler top level: one request in, one command per cylinder out
// a new request may enter while earlier ones are still in the pipeline; busy spaces them for the single command lane
// busy is raised after each accepted item and start is ignored while it is high; commands leave on consecutive cycles
// synchronous active-low reset clears all valids, the sequencer and wheel_teeth
module spark_delay_scheduler_unit #(
    parameter int CYLINDERS       = sds_pkg::DEF_CYLINDERS,
    parameter int ANGLE_FRAC_BITS = sds_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sds_pkg::t_item            i_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sds_pkg::TEETH_W-1:0] i_cfg_data,
    output logic                      o_strobe,
    output sds_pkg::t_result          o_result
);
    import sds_pkg::*;

    localparam int     F      = ANGLE_FRAC_BITS;
    localparam int     RW     = $clog2(CYCLE_DEG);
    localparam int     AW     = RW + F;
    localparam longint FULL_L = longint'(CYCLE_DEG) << F;
    localparam longint HALF_L = longint'(HALF_DEG) << F;
    localparam logic [AW-1:0] FULL = AW'(FULL_L);
    localparam int     CW     = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int     DW     = $clog2(((longint'(1) << TOOTH_W) - 1) * HALF_L + 1);

    localparam int XW  = ADV_W + F + 1;
    localparam int AK  = XW + 4;
    localparam int AMW = AK - ($clog2(ADV_SCALE) - 1);
    localparam logic [AMW-1:0] AM = AMW'((longint'(1) << AK) / ADV_SCALE);
    localparam int APW = XW + AMW;

    localparam int MXW = DW + 1;
    localparam int YW  = MXW - F;
    localparam int MK  = YW + 10;
    localparam int MMW = MK - (RW - 1);
    localparam logic [MMW-1:0] MM = MMW'((longint'(1) << MK) / CYCLE_DEG);
    localparam int MPW = YW + MMW;

    localparam int PRW = AW + TPD_W;
    localparam int DSH = F + TPD_FRAC_BITS;
    localparam int DLW = PRW - DSH;

    typedef struct packed {
        logic [ADV_W-1:0] adv;
        logic [RPM_W-1:0] rpm;
        logic [TPD_W-1:0] tpd;
        logic             rev;
        logic             sched;
    } t_front;

    localparam int TW = $bits(t_front) + AW;

    typedef struct packed {
        logic [CW-1:0]    idx;
        logic             sched;
        logic [ADV_W-1:0] adv;
        logic [RPM_W-1:0] rpm;
        logic [TPD_W-1:0] tpd;
        logic             last;
    } t_lane;

    logic [AW-1:0] w_tdc [CYLINDERS];
    for (genvar g = 0; g < CYLINDERS; g++) begin : g_tdc
        localparam longint TDC_V = (longint'(g) * FULL_L) / CYLINDERS;
        assign w_tdc[g] = AW'(TDC_V);
    end

    // control
    logic [TEETH_W-1:0] r_teeth;
    logic [CW-1:0]      r_gap;
    logic               w_accept;

    assign busy        = (r_gap != '0);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // front stages
    logic            r_s1_vld, r_s2_vld, r_s3_vld;
    t_front          r_s1_f, r_s2_f, r_s3_f, n_s1_f;
    logic [DW-1:0]   r_s1_div, r_s2_div, r_s3_div;
    logic [XW-1:0]   r_s1_num, r_s2_num;
    logic [APW-1:0]  r_s2_prod;
    logic [AW-1:0]   r_s3_adva, n_s3_adva;
    logic [XW-3-1:0] w_aq;
    logic [XW-1:0]   w_ar;

    always_comb begin
        n_s1_f.adv   = i_item.advance_tenths;
        n_s1_f.rpm   = i_item.engine_rpm;
        n_s1_f.tpd   = i_item.us_per_deg;
        n_s1_f.rev   = i_item.crank_rev;
        n_s1_f.sched = i_item.crank_pos_ok && i_item.pattern_locked && (r_teeth != '0);
    end

    // rounded advance / 10 by reciprocal, one correction step
    assign w_aq      = r_s2_prod[APW-1:AK];
    assign w_ar      = r_s2_num - XW'(w_aq) * XW'(ADV_SCALE);
    assign n_s3_adva = AW'(w_aq) + AW'(w_ar >= XW'(ADV_SCALE));

    // tooth divider
    logic          w_div_vld;
    logic [DW-1:0] w_div_quo;
    logic [TW-1:0] w_div_tag;
    t_front        w_div_f;
    logic [AW-1:0] w_div_adva;

    sds_div #(
        .DW    (DW),
        .TW    (TW),
        .STEPS (DIV_STEPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s3_vld),
        .i_dividend (r_s3_div),
        .i_divisor  ({1'b0, r_teeth} + (TEETH_W + 1)'(MISSING_TEETH)),
        .i_tag      ({r_s3_f, r_s3_adva}),
        .o_valid    (w_div_vld),
        .o_quotient (w_div_quo),
        .o_tag      (w_div_tag)
    );

    assign w_div_f    = w_div_tag[TW-1:AW];
    assign w_div_adva = w_div_tag[AW-1:0];

    // crank angle mod 720 degrees
    logic            r_m1_vld, r_m2_vld, r_m3_vld;
    t_front          r_m1_f, r_m2_f, r_m3_f;
    logic [AW-1:0]   r_m1_adva, r_m2_adva, r_m3_adva;
    logic [MXW-1:0]  r_m1_x;
    logic [YW-1:0]   r_m2_y;
    logic [F-1:0]    r_m2_lo;
    logic [MPW-1:0]  r_m2_prod;
    logic [AW-1:0]   r_m3_cur;
    logic [MPW-MK-1:0] w_mq;
    logic [YW-1:0]   w_mr, w_mr2;

    assign w_mq  = r_m2_prod[MPW-1:MK];
    assign w_mr  = r_m2_y - YW'(w_mq) * YW'(CYCLE_DEG);
    assign w_mr2 = (w_mr >= YW'(CYCLE_DEG)) ? (w_mr - YW'(CYCLE_DEG)) : w_mr;

    // command sequencer
    t_front        r_h_f;
    logic [AW-1:0] r_h_adva, r_h_cur;
    logic          r_act;
    logic [CW-1:0] r_idx;

    // command lane
    logic          r_l1_vld, r_l2_vld, r_l3_vld, r_l4_vld;
    t_lane         r_l1, r_l2, r_l3, r_l4, n_l1;
    logic [AW-1:0] r_l1_adva, r_l1_cur, r_l2_spark, r_l2_cur, r_l3_dist;
    logic [AW-1:0] n_spark, n_dist, w_tdc_c;
    logic [PRW-1:0] r_l4_prod;
    logic [DLW-1:0] w_dl;
    logic [DELAY_W-1:0] w_sat;
    logic          r_out_vld;
    t_result       r_out, n_out;

    always_comb begin
        n_l1.idx   = r_idx;
        n_l1.sched = r_h_f.sched;
        n_l1.adv   = r_h_f.adv;
        n_l1.rpm   = r_h_f.rpm;
        n_l1.tpd   = r_h_f.tpd;
        n_l1.last  = (r_idx == CW'(CYLINDERS - 1));
    end

    assign w_tdc_c = w_tdc[r_l1.idx];
    assign n_spark = (w_tdc_c >= r_l1_adva) ? (w_tdc_c - r_l1_adva)
                                            : (w_tdc_c + FULL - r_l1_adva);
    assign n_dist  = (r_l2_spark >= r_l2_cur) ? (r_l2_spark - r_l2_cur)
                                              : (r_l2_spark + FULL - r_l2_cur);

    assign w_dl  = r_l4_prod[PRW-1:DSH];
    assign w_sat = (w_dl > DLW'(DELAY_MAX)) ? DELAY_MAX : w_dl[DELAY_W-1:0];

    always_comb begin
        n_out.cylinder     = CYL_W'(r_l4.idx) + CYL_W'(1);
        n_out.command_kind = r_l4.sched ? KIND_SCHEDULED : KIND_FALLBACK;
        n_out.countdown_us = r_l4.sched ? w_sat : '0;
        n_out.advance_out  = r_l4.sched ? '0 : r_l4.adv;
        n_out.rpm_out      = r_l4.rpm;
        n_out.last         = r_l4.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teeth   <= '0;
            r_gap     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_m3_vld  <= 1'b0;
            r_act     <= 1'b0;
            r_idx     <= '0;
            r_l1_vld  <= 1'b0;
            r_l2_vld  <= 1'b0;
            r_l3_vld  <= 1'b0;
            r_l4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_teeth <= i_cfg_data;
            end
            if (w_accept) begin
                r_gap <= CW'(CYLINDERS - 1);
            end else if (r_gap != '0) begin
                r_gap <= r_gap - CW'(1);
            end
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_m1_vld <= w_div_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            if (r_m3_vld) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (r_act) begin
                if (r_idx == CW'(CYLINDERS - 1)) begin
                    r_act <= 1'b0;
                end
                r_idx <= r_idx + CW'(1);
            end
            r_l1_vld  <= r_act;
            r_l2_vld  <= r_l1_vld;
            r_l3_vld  <= r_l2_vld;
            r_l4_vld  <= r_l3_vld;
            r_out_vld <= r_l4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_f    <= n_s1_f;
        r_s1_div  <= DW'(i_item.tooth_num) * DW'(HALF_L);
        r_s1_num  <= (XW'(i_item.advance_tenths) << F) + XW'(ADV_ROUND);
        r_s2_f    <= r_s1_f;
        r_s2_div  <= r_s1_div;
        r_s2_num  <= r_s1_num;
        r_s2_prod <= APW'(r_s1_num) * APW'(AM);
        r_s3_f    <= r_s2_f;
        r_s3_div  <= r_s2_div;
        r_s3_adva <= n_s3_adva;

        r_m1_f    <= w_div_f;
        r_m1_adva <= w_div_adva;
        r_m1_x    <= MXW'(w_div_quo) + (w_div_f.rev ? MXW'(HALF_L) : '0);
        r_m2_f    <= r_m1_f;
        r_m2_adva <= r_m1_adva;
        r_m2_y    <= r_m1_x[MXW-1:F];
        r_m2_lo   <= r_m1_x[F-1:0];
        r_m2_prod <= MPW'(r_m1_x[MXW-1:F]) * MPW'(MM);
        r_m3_f    <= r_m2_f;
        r_m3_adva <= r_m2_adva;
        r_m3_cur  <= {w_mr2[RW-1:0], r_m2_lo};

        if (r_m3_vld) begin
            r_h_f    <= r_m3_f;
            r_h_adva <= r_m3_adva;
            r_h_cur  <= r_m3_cur;
        end

        r_l1       <= n_l1;
        r_l1_adva  <= r_h_adva;
        r_l1_cur   <= r_h_cur;
        r_l2       <= r_l1;
        r_l2_spark <= n_spark;
        r_l2_cur   <= r_l1_cur;
        r_l3       <= r_l2;
        r_l3_dist  <= n_dist;
        r_l4       <= r_l3;
        r_l4_prod  <= PRW'(r_l3_dist) * PRW'(r_l3.tpd);
        r_out      <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    a_gap_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && CYLINDERS > 1) |=> busy)
        else $error("busy not raised after an accepted item");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("command run broken before its last command");

    a_run_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> (!o_strobe || o_result.cylinder == CYL_W'(1)))
        else $error("new command run does not start at the first cylinder");

    a_last_cylinder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> (o_result.cylinder == CYL_W'(CYLINDERS)))
        else $error("last flag on the wrong cylinder");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for the spark delay scheduler: random and directed requests checked against a predictor
module tb_top;

    import sds_pkg::*;

    localparam int NCYL = DEF_CYLINDERS;
    localparam int FRAC = DEF_ANGLE_FRAC_BITS;
    localparam longint unsigned FULL_ANG = longint'(CYCLE_DEG) << FRAC;
    localparam longint unsigned HALF_ANG = longint'(HALF_DEG) << FRAC;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 33;

    class spark_board;
        t_result pending_cmds[$];
        logic [TEETH_W-1:0] teeth;
        int errors;
        int requests;
        int checked;

        function new();
            teeth = '0;
            errors = 0;
            requests = 0;
            checked = 0;
        endfunction

        task flag(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void note_request(t_item it);
            longint unsigned cur, adv_ang, tdc, spark, fwd, prod;
            t_result r;
            bit synced;
            synced = it.crank_pos_ok && it.pattern_locked && (teeth != 0);
            cur = 0;
            adv_ang = 0;
            if (synced) begin
                cur = (longint'(it.crank_rev) * HALF_ANG
                       + (longint'(it.tooth_num) * HALF_ANG)
                         / (longint'(teeth) + MISSING_TEETH)) % FULL_ANG;
                adv_ang = ((longint'(it.advance_tenths) << FRAC) + ADV_ROUND) / ADV_SCALE;
            end
            for (int c = 0; c < NCYL; c++) begin
                r.cylinder = CYL_W'(c + 1);
                r.rpm_out = it.engine_rpm;
                r.last = (c == NCYL - 1);
                if (synced) begin
                    tdc = (longint'(c) * FULL_ANG) / NCYL;
                    spark = (tdc + FULL_ANG - adv_ang) % FULL_ANG;
                    fwd = (spark >= cur) ? spark - cur : spark + FULL_ANG - cur;
                    prod = (fwd * longint'(it.us_per_deg)) >> (FRAC + TPD_FRAC_BITS);
                    if (prod > longint'(DELAY_MAX)) begin
                        prod = longint'(DELAY_MAX);
                    end
                    r.command_kind = KIND_SCHEDULED;
                    r.countdown_us = prod[DELAY_W-1:0];
                    r.advance_out = '0;
                end else begin
                    r.command_kind = KIND_FALLBACK;
                    r.countdown_us = '0;
                    r.advance_out = it.advance_tenths;
                end
                pending_cmds.push_back(r);
            end
            requests++;
        endfunction

        task check_command(t_result got);
            t_result want;
            if (pending_cmds.size() == 0) begin
                flag($sformatf("unexpected command for cylinder %0d", got.cylinder));
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (got.cylinder !== want.cylinder)
                flag($sformatf("cylinder %0d, want %0d", got.cylinder, want.cylinder));
            if (got.command_kind !== want.command_kind)
                flag($sformatf("cyl %0d kind %0d, want %0d", want.cylinder,
                               got.command_kind, want.command_kind));
            if (got.countdown_us !== want.countdown_us)
                flag($sformatf("cyl %0d delay %0d, want %0d", want.cylinder,
                               got.countdown_us, want.countdown_us));
            if (got.advance_out !== want.advance_out)
                flag($sformatf("cyl %0d advance %0d, want %0d", want.cylinder,
                               got.advance_out, want.advance_out));
            if (got.rpm_out !== want.rpm_out)
                flag($sformatf("cyl %0d rpm %0d, want %0d", want.cylinder,
                               got.rpm_out, want.rpm_out));
            if (got.last !== want.last)
                flag($sformatf("cyl %0d last %0d, want %0d", want.cylinder,
                               got.last, want.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_item i_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [TEETH_W-1:0] i_cfg_data;
    logic o_strobe;
    t_result o_result;

    spark_board sb;
    int cfg_writes;

    spark_delay_scheduler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_command(o_result);
        end
    end

    function automatic t_item make_request(int adv, int rpm, bit sv, bit sa, bit rev,
                                           int tooth, int tpd);
        t_item it;
        it.advance_tenths = ADV_W'(adv);
        it.engine_rpm = RPM_W'(rpm);
        it.crank_pos_ok = sv;
        it.pattern_locked = sa;
        it.crank_rev = rev;
        it.tooth_num = TOOTH_W'(tooth);
        it.us_per_deg = TPD_W'(tpd);
        return it;
    endfunction

    function automatic t_item random_request(int teeth);
        t_item it;
        int top;
        top = (teeth + 1 > 255) ? 255 : teeth + 1;
        it.advance_tenths = ($urandom_range(0, 7) == 0) ? ADV_W'($urandom)
                                                        : ADV_W'($urandom_range(0, 1000));
        it.engine_rpm = ($urandom_range(0, 3) == 0) ? RPM_W'($urandom)
                                                    : RPM_W'($urandom_range(0, 16000));
        if ($urandom_range(0, 9) < 8) begin
            it.crank_pos_ok = 1'b1;
            it.pattern_locked = 1'b1;
        end else begin
            it.crank_pos_ok = 1'($urandom);
            it.pattern_locked = 1'($urandom);
        end
        it.crank_rev = 1'($urandom);
        it.tooth_num = ($urandom_range(0, 7) == 0) ? TOOTH_W'($urandom)
                                                   : TOOTH_W'($urandom_range(0, top));
        case ($urandom_range(0, 3))
            0: it.us_per_deg = TPD_W'($urandom);
            1: it.us_per_deg = TPD_W'($urandom_range(0, 16'h3fff));
            2: it.us_per_deg = TPD_W'($urandom_range(16'h0100, 20'hfffff));
            default: it.us_per_deg = TPD_W'($urandom_range(24'hf00000, 24'hffffff));
        endcase
        return it;
    endfunction

    task idle_burst(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task send_request(t_item it);
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_request(it);
    endtask

    task wait_all_commands();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task write_teeth(logic [TEETH_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.teeth = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int teeth_plan[PHASES];
        int waited;
        bit quiet;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        cfg_writes = 0;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wheel_teeth still zero after reset
        send_request(make_request(1023, 16383, 1, 1, 1, 255, 24'hffffff));
        send_request(make_request(0, 0, 0, 0, 0, 0, 0));
        wait_all_commands();

        write_teeth(8'd58);
        send_request(make_request(150, 3000, 0, 1, 0, 10, 24'h001500));
        send_request(make_request(150, 3000, 1, 0, 0, 10, 24'h001500));
        send_request(make_request(1000, 16000, 0, 0, 1, 255, 24'hffffff));
        send_request(make_request(0, 800, 1, 1, 0, 0, 24'h001500));
        send_request(make_request(0, 800, 1, 1, 0, 0, 0));
        send_request(make_request(1023, 16383, 1, 1, 1, 59, 24'hffffff));
        send_request(make_request(5, 1200, 1, 1, 0, 1, 24'h000100));
        send_request(make_request(1000, 6000, 1, 1, 1, 30, 24'h000040));
        send_request(make_request(300, 2500, 1, 1, 0, 255, 24'h002000));
        send_request(make_request(300, 2500, 1, 1, 1, 255, 24'h002000));
        send_request(make_request(1, 9000, 1, 1, 1, 59, 24'h000001));
        send_request(make_request(999, 12000, 1, 1, 0, 29, 24'hffff00));
        send_request(make_request(512, 1, 1, 1, 1, 58, 24'h800000));
        wait_all_commands();

        write_teeth(8'd255);
        send_request(make_request(200, 4000, 1, 1, 1, 255, 24'hffffff));
        send_request(make_request(200, 4000, 1, 1, 0, 0, 24'h003000));
        send_request(make_request(700, 4000, 1, 1, 1, 128, 24'h001234));
        wait_all_commands();

        write_teeth(8'd1);
        send_request(make_request(100, 1000, 1, 1, 0, 255, 24'h004000));
        send_request(make_request(100, 1000, 1, 1, 1, 1, 24'h004000));
        send_request(make_request(100, 1000, 1, 1, 0, 2, 24'h004000));
        wait_all_commands();

        teeth_plan = '{58, 0, 255, 1, $urandom_range(2, 254), 34, $urandom_range(1, 255)};
        for (int p = 0; p < PHASES; p++) begin
            write_teeth(TEETH_W'(teeth_plan[p]));
            quiet = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (!quiet && $urandom_range(0, 2) == 0) begin
                    idle_burst($urandom_range(1, 19));
                end
                send_request(random_request(teeth_plan[p]));
            end
            wait_all_commands();
        end

        waited = 0;
        while (sb.pending_cmds.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.pending_cmds.size() != 0) begin
            sb.flag($sformatf("%0d commands never arrived", sb.pending_cmds.size()));
        end
        $display("ran %0d requests across %0d wheel tooth settings, %0d commands checked",
                 sb.requests, cfg_writes + 1, sb.checked);
        $display("covered fallback and scheduled commands, saturation, zero rate, wrap");
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sds_pkg.sv
rtl/sds_div.sv
rtl/spark_delay_scheduler_unit.sv
verif/tb_top.sv
